/* sv/lkv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkv_pkg;

   localparam int CAP_W = 5;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   localparam logic [CAP_W-1:0]        CAP_RESET  = 5'd16;
   localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // One stored entry as it moves along the chain.
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } lkv_entry_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic capture;   // register the key compare for a newly accepted word
      logic move_hit;  // move the matching entry to the head
      logic insert;    // push a new entry in at the head
      logic full;      // store holds the effective capacity or more
   } lkv_cell_ctl_type;

endpackage
`default_nettype wire

/* sv/lkv_channels.sv */
// Request and response channel interfaces of the LRU key-value cache.
`default_nettype none
interface lkv_req_if;
   import lkv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [KEY_W-1:0] key;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
   import lkv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] value_out;

   modport source (output valid, output hit, output value_out, input ready);
   modport sink   (input valid, input hit, input value_out, output ready);
endinterface
`default_nettype wire

/* sv/lkv_cell.sv */
// One cell of the recency chain: holds one entry, compares its key and shifts from its neighbor.
`default_nettype none
module lkv_cell import lkv_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lkv_cell_ctl_type        ctl,
   input  wire logic signed [KEY_W-1:0] cmp_key,
   input  wire lkv_entry_type           up_entry,
   output lkv_entry_type                entry,
   input  wire logic                    hit_below,
   output logic                         hit_here_or_below,
   input  wire logic signed [VAL_W-1:0] value_below,
   output logic signed [VAL_W-1:0]      value_here_or_below,
   output logic                         matched
);

   logic                    valid_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic                    match_ff;
   logic                    shift;

   assign entry               = '{valid: valid_ff, key: key_ff, value: value_ff};
   assign matched             = match_ff;
   assign hit_here_or_below   = match_ff | hit_below;
   assign value_here_or_below = (match_ff ? value_ff : '0) | value_below;

   // A hit moves the cells from the head down to the match; an insert moves every
   // occupied cell, plus the first free one when there is room.
   always_comb begin
      if (ctl.move_hit) begin
         shift = hit_here_or_below;
      end else if (ctl.insert) begin
         shift = ctl.full ? valid_ff : up_entry.valid;
      end else begin
         shift = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.capture) begin
            match_ff <= valid_ff && (key_ff == cmp_key);
         end
         if (shift) begin
            valid_ff <= up_entry.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= up_entry.key;
         value_ff <= up_entry.value;
      end
   end

endmodule
`default_nettype wire

/* sv/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: request control, capacity register and the cell chain.
//
// Usage:
//   req_if  : request words {func, key, value}; func GET looks up key, func PUT
//             writes value under key. Accepted when valid and ready are high.
//   rsp_if  : one response word {hit, value_out} per GET; value_out is -1 on a
//             miss. PUT produces no response.
//   csr_wr_en / csr_wr_data : capacity register, written while the cache is idle.
//             Zero acts as one, values above ENTRIES act as ENTRIES.
// Entries sit in a chain of cells ordered by recency, head = most recent.
// The accept cycle registers the key compare in every cell; ST_APPLY then shifts
// the chain and loads the response register. A new request is not accepted
// until the previous one leaves ST_APPLY.
// Reset empties the store and sets capacity to 16. A stalled response stays in
// its output register; the next request is still accepted, but a GET behind it
// holds in ST_APPLY until the pending response is taken.
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lkv_req_if.sink               req_if,
   lkv_rsp_if.source             rsp_if,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int UW = $clog2(ENTRIES + 1);
   localparam int CW = (UW > CAP_W) ? UW : CAP_W;

   typedef enum logic {ST_IDLE, ST_APPLY} state_type;

   state_type               state_ff;
   logic [CAP_W-1:0]        capacity_ff;
   logic [UW-1:0]           used_ff;
   logic                    func_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;

   logic                    req_fire;
   logic                    rsp_free;
   logic                    finish;
   logic                    apply_go;
   logic                    any_hit;
   logic                    full;
   logic [CW-1:0]           cap_ext;
   logic [CW-1:0]           eff_cap;
   lkv_cell_ctl_type        ctl;
   lkv_entry_type           head_entry;

   lkv_entry_type           chain [ENTRIES+1];
   logic                    hit_chain [ENTRIES+1];
   logic signed [VAL_W-1:0] val_chain [ENTRIES+1];
   logic [ENTRIES-1:0]      match_vec;
   logic [ENTRIES-1:0]      valid_vec;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_fire         = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.hit       = rsp_hit_ff;
   assign rsp_if.value_out = rsp_value_ff;

   assign cap_ext = CW'(capacity_ff);
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign full = CW'(used_ff) >= eff_cap;

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign finish   = (func_ff == FUNC_PUT) || rsp_free;
   assign apply_go = (state_ff == ST_APPLY) && finish;
   assign any_hit  = hit_chain[0];

   assign ctl.capture  = req_fire;
   assign ctl.move_hit = apply_go && any_hit;
   assign ctl.insert   = apply_go && (func_ff == FUNC_PUT) && !any_hit;
   assign ctl.full     = full;

   // Head of the chain: a put carries its new value, a get hit carries the stored one.
   assign head_entry.valid = 1'b1;
   assign head_entry.key   = key_ff;
   assign head_entry.value = (func_ff == FUNC_PUT) ? value_ff : val_chain[0];

   assign chain[0]           = head_entry;
   assign hit_chain[ENTRIES] = 1'b0;
   assign val_chain[ENTRIES] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock               (clock),
         .reset               (reset),
         .ctl                 (ctl),
         .cmp_key             (req_if.key),
         .up_entry            (chain[i]),
         .entry               (chain[i+1]),
         .hit_below           (hit_chain[i+1]),
         .hit_here_or_below   (hit_chain[i]),
         .value_below         (val_chain[i+1]),
         .value_here_or_below (val_chain[i]),
         .matched             (match_vec[i])
      );
      assign valid_vec[i] = chain[i+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         // drop the taken word unless a new one loads in the same cycle
         if (rsp_valid_ff && rsp_if.ready && !(apply_go && (func_ff == FUNC_GET))) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  func_ff  <= req_if.func;
                  key_ff   <= req_if.key;
                  value_ff <= req_if.value;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (finish) begin
                  state_ff <= ST_IDLE;
                  if (func_ff == FUNC_GET) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_hit_ff   <= any_hit;
                     rsp_value_ff <= any_hit ? val_chain[0] : MISS_VALUE;
                  end
                  // grow only when a free cell takes the new entry
                  if (ctl.insert && !full) begin
                     used_ff <= used_ff + UW'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matched the key");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(used_ff))
      else $error("occupied cells disagree with used count");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(ENTRIES))
      else $error("used count above number of cells");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY) && $past(func_ff == FUNC_GET))
      else $error("response raised outside a get");

   a_accept_to_apply: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_APPLY)
      else $error("accepted word did not enter apply");

endmodule
`default_nettype wire
